// ===== hdl/grt_pkg.sv =====
// shared types, constants and helper functions for the gnss report throttle
// no dependencies; used by the interfaces and every module of the block
package grt_pkg;

  localparam int WINDOW_LEN = 100;

  localparam int SPEED_W = 14;
  localparam int RUN_W   = 8;
  localparam int CNT_W   = 16;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // window sum never holds more than WINDOW_LEN full-scale speeds
  localparam int SUM_W  = $clog2(WINDOW_LEN * (2 ** SPEED_W));
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  // sum / WINDOW_LEN as a multiply by a rounded-up reciprocal; the shift is
  // wide enough that the reciprocal error stays below one part in WINDOW_LEN
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN) + 1;
  localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [SPEED_W-1:0]    LOW_SPEED_RST = 14'd0;
  localparam logic [RUN_W-1:0]      STARTUP_RST   = 8'd10;
  localparam logic [CNT_W-1:0]      PERIOD_RST    = 16'd200;
  localparam logic [CNT_W-1:0]      ERR50_RST     = 16'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_SPEED = 2'd0,
    REG_STARTUP   = 2'd1,
    REG_PERIOD    = 2'd2,
    REG_ERR50     = 2'd3
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    ERR_OTHER  = 2'd0,
    ERR_516    = 2'd1,
    ERR_50     = 2'd2,
    ERR_UNUSED = 2'd3
  } err_kind_t;

  typedef struct packed {
    logic [SPEED_W-1:0] low_speed_limit;
    logic [RUN_W-1:0]   startup_reports;
    logic [CNT_W-1:0]   forced_period;
    logic [CNT_W-1:0]   error50_limit;
  } cfg_t;

  typedef struct packed {
    logic               reply_ok;
    logic               fields_ok;
    logic [SPEED_W-1:0] speed_tenth_kmh;
    logic [KIND_W-1:0]  error_kind;
  } fix_t;

  typedef struct packed {
    logic               publish;
    logic [SPEED_W-1:0] mean_speed_tenth_kmh;
    logic               mean_updated;
    logic               restart_request;
    logic [CNT_W-1:0]   error50_count;
    logic [CNT_W-1:0]   error516_count;
  } result_t;

  // run counter step: advance while not past the limit, saturate at max
  function automatic logic [RUN_W-1:0] run_advance(logic [RUN_W-1:0] run,
                                                   logic [RUN_W-1:0] n);
    logic [RUN_W-1:0] res;
    res = run;
    if (run <= n && run != RUN_MAX) begin
      res = run + RUN_W'(1);
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    res = cnt;
    if (cnt != CNT_MAX) begin
      res = cnt + CNT_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== hdl/grt_ifs.sv =====
// valid/ready channel interfaces for fix items, result items and config writes
// depends on grt_pkg for field widths
interface grt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          reply_ok;
  logic                          fields_ok;
  logic [grt_pkg::SPEED_W-1:0]   speed_tenth_kmh;
  logic [grt_pkg::KIND_W-1:0]    error_kind;

  modport source (output valid, reply_ok, fields_ok, speed_tenth_kmh, error_kind,
                  input ready);
  modport sink   (input valid, reply_ok, fields_ok, speed_tenth_kmh, error_kind,
                  output ready);
endinterface

interface grt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          publish;
  logic [grt_pkg::SPEED_W-1:0]   mean_speed_tenth_kmh;
  logic                          mean_updated;
  logic                          restart_request;
  logic [grt_pkg::CNT_W-1:0]     error50_count;
  logic [grt_pkg::CNT_W-1:0]     error516_count;

  modport source (output valid, publish, mean_speed_tenth_kmh, mean_updated,
                  restart_request, error50_count, error516_count,
                  input ready);
  modport sink   (input valid, publish, mean_speed_tenth_kmh, mean_updated,
                  restart_request, error50_count, error516_count,
                  output ready);
endinterface

interface grt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [grt_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [grt_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== hdl/grt_cfg_regs.sv =====
// configuration register bank, written through the cfg channel
// depends on grt_pkg and grt_cfg_if
module grt_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  grt_cfg_if.sink         cfg_if,
  output grt_pkg::cfg_t   cfg
);

  grt_pkg::cfg_t cfg_r;
  grt_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (grt_pkg::cfg_reg_t'(cfg_if.reg_index))
        grt_pkg::REG_LOW_SPEED:
          cfg_nxt.low_speed_limit = cfg_if.wdata[grt_pkg::SPEED_W-1:0];
        grt_pkg::REG_STARTUP:
          cfg_nxt.startup_reports = cfg_if.wdata[grt_pkg::RUN_W-1:0];
        grt_pkg::REG_PERIOD:
          cfg_nxt.forced_period = cfg_if.wdata[grt_pkg::CNT_W-1:0];
        grt_pkg::REG_ERR50:
          cfg_nxt.error50_limit = cfg_if.wdata[grt_pkg::CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_speed_limit <= grt_pkg::LOW_SPEED_RST;
      cfg_r.startup_reports <= grt_pkg::STARTUP_RST;
      cfg_r.forced_period   <= grt_pkg::PERIOD_RST;
      cfg_r.error50_limit   <= grt_pkg::ERR50_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/grt_engine.sv =====
// per-fix decision logic and tracking state: speed window, run counters,
// forced-publish phase and failure counters; depends on grt_pkg
module grt_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fix_acc,
  input  grt_pkg::fix_t     fix,
  input  grt_pkg::cfg_t     cfg,
  output grt_pkg::result_t  res
);

  logic [grt_pkg::SUM_W-1:0]   sum_r,    sum_nxt;
  logic [grt_pkg::FILL_W-1:0]  fill_r,   fill_nxt;
  logic [grt_pkg::SPEED_W-1:0] mean_r,   mean_nxt;
  logic [grt_pkg::RUN_W-1:0]   sent_r,   sent_nxt;
  logic [grt_pkg::RUN_W-1:0]   slow_r,   slow_nxt;
  logic [grt_pkg::CNT_W-1:0]   phase_r,  phase_nxt;
  logic [grt_pkg::CNT_W-1:0]   f50_r,    f50_nxt;
  logic [grt_pkg::CNT_W-1:0]   f516_r,   f516_nxt;

  logic [grt_pkg::SUM_W-1:0]   sum_add;
  logic [grt_pkg::FILL_W-1:0]  fill_inc;
  logic                        window_done;
  logic [grt_pkg::PROD_W-1:0]  prod;
  logic [grt_pkg::SPEED_W-1:0] mean_calc;
  logic                        slow;
  logic [grt_pkg::CNT_W-1:0]   period;
  logic [grt_pkg::CNT_W:0]     phase_inc;

  assign sum_add     = sum_r + grt_pkg::SUM_W'(fix.speed_tenth_kmh);
  assign fill_inc    = fill_r + grt_pkg::FILL_W'(1);
  assign window_done = (fill_inc >= grt_pkg::FILL_W'(grt_pkg::WINDOW_LEN));
  // divide by the window length through the reciprocal
  assign prod        = grt_pkg::PROD_W'(sum_add) *
                       grt_pkg::PROD_W'(grt_pkg::RECIP);
  assign mean_calc   = grt_pkg::SPEED_W'(prod >> grt_pkg::RECIP_SHIFT);

  assign slow      = fix.fields_ok && (fix.speed_tenth_kmh <= cfg.low_speed_limit);
  assign period    = (cfg.forced_period == '0) ? grt_pkg::CNT_W'(1) : cfg.forced_period;
  assign phase_inc = {1'b0, phase_r} + (grt_pkg::CNT_W + 1)'(1);

  always_comb begin
    sum_nxt   = sum_r;
    fill_nxt  = fill_r;
    mean_nxt  = mean_r;
    sent_nxt  = sent_r;
    slow_nxt  = slow_r;
    phase_nxt = phase_r;
    f50_nxt   = f50_r;
    f516_nxt  = f516_r;
    res       = '0;

    if (fix.reply_ok) begin
      if (fix.fields_ok) begin
        if (window_done) begin
          sum_nxt          = '0;
          fill_nxt         = '0;
          mean_nxt         = mean_calc;
          res.mean_updated = 1'b1;
        end else begin
          sum_nxt  = sum_add;
          fill_nxt = fill_inc;
        end
      end else begin
        // unparsed fix clears the window and mean
        sum_nxt  = '0;
        fill_nxt = '0;
        mean_nxt = '0;
      end

      slow_nxt = slow ? grt_pkg::run_advance(slow_r, cfg.startup_reports) : '0;
      sent_nxt = grt_pkg::run_advance(sent_r, cfg.startup_reports);

      res.publish = (sent_nxt <= cfg.startup_reports) ||
                    (slow_nxt <= cfg.startup_reports) ||
                    (phase_r == '0);

      // phase also wraps when the period was lowered below it
      phase_nxt = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[grt_pkg::CNT_W-1:0];

      f50_nxt  = '0;
      f516_nxt = '0;
    end else begin
      sum_nxt  = '0;
      fill_nxt = '0;
      mean_nxt = '0;
      sent_nxt = '0;
      slow_nxt = '0;
      unique case (grt_pkg::err_kind_t'(fix.error_kind))
        grt_pkg::ERR_516: f516_nxt = grt_pkg::sat_inc(f516_r);
        grt_pkg::ERR_50:  f50_nxt  = grt_pkg::sat_inc(f50_r);
        default: begin
          f50_nxt  = f50_r;
          f516_nxt = f516_r;
        end
      endcase
      res.restart_request = (f50_nxt >= cfg.error50_limit);
    end

    res.mean_speed_tenth_kmh = mean_nxt;
    res.error50_count        = f50_nxt;
    res.error516_count       = f516_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      fill_r  <= '0;
      mean_r  <= '0;
      sent_r  <= '0;
      slow_r  <= '0;
      phase_r <= '0;
      f50_r   <= '0;
      f516_r  <= '0;
    end else if (fix_acc) begin
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      mean_r  <= mean_nxt;
      sent_r  <= sent_nxt;
      slow_r  <= slow_nxt;
      phase_r <= phase_nxt;
      f50_r   <= f50_nxt;
      f516_r  <= f516_nxt;
    end
  end

endmodule

// ===== hdl/grt_out_buf.sv =====
// two-entry result buffer: two slots used in turn through write and read pointers
// depends on grt_pkg
module grt_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  grt_pkg::result_t  push_data,
  output logic              can_push,
  input  logic              pop,
  output logic              has_data,
  output grt_pkg::result_t  head
);

  grt_pkg::result_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r,    cnt_nxt;

  assign can_push = (cnt_r != 2'd2);
  assign has_data = (cnt_r != 2'd0);
  assign head     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/gnss_report_throttle_core.sv =====
// gnss report throttle: publish decision, windowed mean speed, failure counters
// depends on grt_pkg, grt_ifs, grt_cfg_regs, grt_engine and grt_out_buf
//
// Usage:
//   in_if carries one fix outcome per item (reply_ok, fields_ok, speed,
//   error_kind). Every accepted item yields exactly one result item on out_if
//   (publish flag, mean speed, window-complete flag, restart request and the
//   two failure counts).
//   cfg_if writes the four settings registers by index; it is always ready
//   and should only be used while no item is in flight.
//   A result is registered in the buffer when its fix item is accepted.
//   Throughput is one item per cycle while the buffer has room; the whole
//   engine decision and mean division (reciprocal multiply) are combinational.
//   Results pass through a two-entry buffer, so one more fix is taken while
//   a result waits; with both entries full in_if.ready drops until out_if
//   takes an item. Nothing is lost or repeated under stalls on either side.
//   Reset clears the window, mean, run counters, phase and failure counts,
//   empties the buffer and loads the settings defaults (low speed 0,
//   startup 10, period 200, error-50 limit 60).
module gnss_report_throttle_core (
  input  logic       clk,
  input  logic       rst_n,
  grt_in_if.sink     in_if,
  grt_out_if.source  out_if,
  grt_cfg_if.sink    cfg_if
);

  grt_pkg::cfg_t     cfg;
  grt_pkg::fix_t     fix;
  grt_pkg::result_t  res;
  grt_pkg::result_t  head;
  logic              fix_acc;
  logic              can_push;
  logic              has_data;
  logic              pop;

  assign fix.reply_ok        = in_if.reply_ok;
  assign fix.fields_ok       = in_if.fields_ok;
  assign fix.speed_tenth_kmh = in_if.speed_tenth_kmh;
  assign fix.error_kind      = in_if.error_kind;

  assign in_if.ready = can_push;
  assign fix_acc     = in_if.valid && can_push;
  assign pop         = has_data && out_if.ready;

  grt_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  grt_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fix_acc (fix_acc),
    .fix     (fix),
    .cfg     (cfg),
    .res     (res)
  );

  grt_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fix_acc),
    .push_data (res),
    .can_push  (can_push),
    .pop       (pop),
    .has_data  (has_data),
    .head      (head)
  );

  assign out_if.valid                = has_data;
  assign out_if.publish              = head.publish;
  assign out_if.mean_speed_tenth_kmh = head.mean_speed_tenth_kmh;
  assign out_if.mean_updated         = head.mean_updated;
  assign out_if.restart_request      = head.restart_request;
  assign out_if.error50_count        = head.error50_count;
  assign out_if.error516_count       = head.error516_count;

endmodule
